[src/k_nearest_neighbour_select_assert.svh]
// Assertion macros for the nearest neighbour select block.
`ifndef K_NEAREST_NEIGHBOUR_SELECT_ASSERT_SVH
`define K_NEAREST_NEIGHBOUR_SELECT_ASSERT_SVH

// same-cycle implication
`define KNNS_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define KNNS_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/knns_pkg.sv]
// Shared types and constants of the nearest neighbour select block.
`default_nettype none

package knns_pkg;

    localparam int NEAREST_COUNT = 4;
    localparam int MAX_POINTS    = 1024;

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int COORD_W = 16;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 1;
    localparam int CNT_W   = $clog2(NEAREST_COUNT + 1);

    localparam logic ACT_REFERENCE = 1'b0;
    localparam logic ACT_CANDIDATE = 1'b1;

    typedef logic [IDX_W-1:0]   t_index;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [SQ_W-1:0]    t_sq;
    typedef logic [DIST_W-1:0]  t_dist;
    typedef logic [CNT_W-1:0]   t_cnt;

    typedef struct packed {
        logic   action;
        t_index point_index;
        t_coord coord_x;
        t_coord coord_y;
        logic   final_candidate;
    } t_in_word;

    typedef struct packed {
        t_index reference_index;
        t_index neighbour_index;
        t_dist  squared_distance;
        logic   entry_valid;
        logic   last_of_run;
    } t_out_word;

    // item leaving the distance pipeline
    typedef struct packed {
        logic   valid;
        logic   action;
        logic   fin;
        t_index idx;
        t_dist  sq_dist;
    } t_cand;

    typedef struct packed {
        logic   valid;
        t_index idx;
        t_dist  sq_dist;
    } t_rank;

    typedef struct packed {
        logic clear;
        logic insert;
        logic rotate;
    } t_cell_ctl;

endpackage

`default_nettype wire

[src/knns_if.sv]
// Valid/ready channel interfaces for input and result words.
`default_nettype none

interface knns_in_if;
    logic                valid;
    logic                ready;
    logic                action;
    knns_pkg::t_index    point_index;
    knns_pkg::t_coord    coord_x;
    knns_pkg::t_coord    coord_y;
    logic                final_candidate;

    modport source (
        output valid, action, point_index, coord_x, coord_y, final_candidate,
        input  ready
    );
    modport sink (
        input  valid, action, point_index, coord_x, coord_y, final_candidate,
        output ready
    );
endinterface

interface knns_out_if;
    logic                valid;
    logic                ready;
    knns_pkg::t_index    reference_index;
    knns_pkg::t_index    neighbour_index;
    knns_pkg::t_dist     squared_distance;
    logic                entry_valid;
    logic                last_of_run;

    modport source (
        output valid, reference_index, neighbour_index, squared_distance,
               entry_valid, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, reference_index, neighbour_index, squared_distance,
               entry_valid, last_of_run,
        output ready
    );
endinterface

`default_nettype wire

[src/k_nearest_neighbour_select.sv]
// Keeps the nearest candidates to a reference point and emits the list on the final candidate.
// A reference word loads the reference point and empties the list; each candidate word
// enters a two-stage distance pipeline (difference, square) and the sum of the squares is
// inserted by a row of rank cells that all compare in the same cycle. Candidates are
// taken one per cycle while input is not held off. After a word with final_candidate set,
// input is held off until that word has left the distance pipeline and the list has been
// rotated out through the output register, one rank per cycle while the output is not
// stalled. The list is kept after output and still takes candidates until the next
// reference word. No clearing pass runs after reset.
`default_nettype none
`include "k_nearest_neighbour_select_assert.svh"

module k_nearest_neighbour_select (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    knns_in_if.sink     i_in,
    knns_out_if.source  o_out
);
    import knns_pkg::*;

    t_in_word  in_word;
    logic      take;
    t_cand     cand;
    logic      fin_pending;
    t_cell_ctl cell_ctl;
    logic      emit_step;

    t_rank                    ranks [NEAREST_COUNT];
    logic [NEAREST_COUNT-1:0] hits;
    logic [NEAREST_COUNT-1:0] prev_hits;
    logic [NEAREST_COUNT-1:0] valids;
    logic [NEAREST_COUNT-1:0] valids_inc;

    t_index    r_run_ref;
    t_cnt      r_emit_cnt;
    logic      r_o_valid;
    t_out_word r_o_word;

    always_comb begin
        in_word.action          = i_in.action;
        in_word.point_index     = i_in.point_index;
        in_word.coord_x         = i_in.coord_x;
        in_word.coord_y         = i_in.coord_y;
        in_word.final_candidate = i_in.final_candidate;
    end

    assign i_in.ready = (r_emit_cnt == '0) && !fin_pending;
    assign take       = i_in.valid && i_in.ready;

    knns_dist u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_word        (in_word),
        .o_cand        (cand),
        .o_fin_pending (fin_pending)
    );

    assign emit_step = (r_emit_cnt != '0) && (!r_o_valid || o_out.ready);

    always_comb begin
        cell_ctl.clear  = cand.valid && cand.action == ACT_REFERENCE;
        cell_ctl.insert = cand.valid && cand.action == ACT_CANDIDATE;
        cell_ctl.rotate = emit_step;
    end

    for (genvar g = 0; g < NEAREST_COUNT; g++) begin : g_rank
        localparam int PREV = (g + NEAREST_COUNT - 1) % NEAREST_COUNT;
        localparam int NEXT = (g + 1) % NEAREST_COUNT;

        assign prev_hits[g] = (g == 0) ? 1'b0 : hits[PREV];
        assign valids[g]    = ranks[g].valid;

        knns_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl),
            .i_prev      (ranks[PREV]),
            .i_next      (ranks[NEXT]),
            .i_prev_hit  (prev_hits[g]),
            .i_cand_idx  (cand.idx),
            .i_cand_dist (cand.sq_dist),
            .o_rank      (ranks[g]),
            .o_hit       (hits[g])
        );
    end

    assign valids_inc = valids + NEAREST_COUNT'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_ref  <= '0;
            r_emit_cnt <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (cell_ctl.clear) begin
                r_run_ref <= cand.idx;
            end
            if (cell_ctl.insert && cand.fin) begin
                r_emit_cnt <= CNT_W'(NEAREST_COUNT);
            end else if (emit_step) begin
                r_emit_cnt <= r_emit_cnt - CNT_W'(1);
            end
            if (emit_step) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // rank 0 is always at the head while rotating out
    always_ff @(posedge i_clk) begin
        if (emit_step) begin
            r_o_word.reference_index  <= r_run_ref;
            r_o_word.neighbour_index  <= ranks[0].valid ? ranks[0].idx : '0;
            r_o_word.squared_distance <= ranks[0].valid ? ranks[0].sq_dist : '0;
            r_o_word.entry_valid      <= ranks[0].valid;
            r_o_word.last_of_run      <= (r_emit_cnt == CNT_W'(1));
        end
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.reference_index  = r_o_word.reference_index;
    assign o_out.neighbour_index  = r_o_word.neighbour_index;
    assign o_out.squared_distance = r_o_word.squared_distance;
    assign o_out.entry_valid      = r_o_word.entry_valid;
    assign o_out.last_of_run      = r_o_word.last_of_run;

    `KNNS_ASSERT_IMP(a_emit_blocks_input, i_clk, i_rst_n, r_emit_cnt != '0, !i_in.ready, "input taken during list output")
    `KNNS_ASSERT_IMP(a_emit_pipe_empty, i_clk, i_rst_n, r_emit_cnt != '0, !cand.valid, "candidate in flight during list output")
    `KNNS_ASSERT_IMP(a_valid_prefix, i_clk, i_rst_n, r_emit_cnt == '0, (valids_inc & valids) == '0, "list holes")
    `KNNS_ASSERT_NXT(a_emit_start, i_clk, i_rst_n, cell_ctl.insert && cand.fin, r_emit_cnt == CNT_W'(NEAREST_COUNT), "list output did not start after final candidate")

endmodule

`default_nettype wire

[src/knns_dist.sv]
// Two-stage squared distance pipeline with the reference point registers.
`default_nettype none

module knns_dist (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire knns_pkg::t_in_word i_word,
    output knns_pkg::t_cand       o_cand,
    output logic                  o_fin_pending
);
    import knns_pkg::*;

    t_coord r_ref_x;
    t_coord r_ref_y;

    logic   r_s1_valid;
    logic   r_s1_action;
    logic   r_s1_fin;
    t_index r_s1_idx;
    t_coord r_s1_dx;
    t_coord r_s1_dy;

    logic   r_s2_valid;
    logic   r_s2_action;
    logic   r_s2_fin;
    t_index r_s2_idx;
    t_sq    r_s2_sqx;
    t_sq    r_s2_sqy;

    t_coord n_dx;
    t_coord n_dy;

    always_comb begin
        n_dx = (i_word.coord_x >= r_ref_x) ? i_word.coord_x - r_ref_x
                                           : r_ref_x - i_word.coord_x;
        n_dy = (i_word.coord_y >= r_ref_y) ? i_word.coord_y - r_ref_y
                                           : r_ref_y - i_word.coord_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x    <= '0;
            r_ref_y    <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_take && i_word.action == ACT_REFERENCE) begin
                r_ref_x <= i_word.coord_x;
                r_ref_y <= i_word.coord_y;
            end
            r_s1_valid <= i_take;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_action <= i_word.action;
        r_s1_fin    <= i_word.final_candidate;
        r_s1_idx    <= i_word.point_index;
        r_s1_dx     <= n_dx;
        r_s1_dy     <= n_dy;

        r_s2_action <= r_s1_action;
        r_s2_fin    <= r_s1_fin;
        r_s2_idx    <= r_s1_idx;
        r_s2_sqx    <= t_sq'(r_s1_dx) * t_sq'(r_s1_dx);
        r_s2_sqy    <= t_sq'(r_s1_dy) * t_sq'(r_s1_dy);
    end

    always_comb begin
        o_cand.valid   = r_s2_valid;
        o_cand.action  = r_s2_action;
        o_cand.fin     = r_s2_fin;
        o_cand.idx     = r_s2_idx;
        o_cand.sq_dist = t_dist'(r_s2_sqx) + t_dist'(r_s2_sqy);
    end

    assign o_fin_pending =
        (r_s1_valid && r_s1_action == ACT_CANDIDATE && r_s1_fin) ||
        (r_s2_valid && r_s2_action == ACT_CANDIDATE && r_s2_fin);

endmodule

`default_nettype wire

[src/knns_cell.sv]
// One rank of the sorted list: compare, insert, shift and rotate.
`default_nettype none

module knns_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire knns_pkg::t_cell_ctl i_ctl,
    input  wire knns_pkg::t_rank     i_prev,
    input  wire knns_pkg::t_rank     i_next,
    input  wire logic                i_prev_hit,
    input  wire knns_pkg::t_index    i_cand_idx,
    input  wire knns_pkg::t_dist     i_cand_dist,
    output knns_pkg::t_rank          o_rank,
    output logic                     o_hit
);
    import knns_pkg::*;

    t_rank r_rank;
    t_rank n_rank;

    // empty rank counts as farther than any distance
    assign o_hit = !r_rank.valid || (i_cand_dist < r_rank.sq_dist);

    always_comb begin
        n_rank = r_rank;
        priority if (i_ctl.clear) begin
            n_rank = '0;
        end else if (i_ctl.rotate) begin
            n_rank = i_next;
        end else if (i_ctl.insert && i_prev_hit) begin
            n_rank = i_prev;
        end else if (i_ctl.insert && o_hit) begin
            n_rank.valid   = 1'b1;
            n_rank.idx     = i_cand_idx;
            n_rank.sq_dist = i_cand_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= '0;
        end else begin
            r_rank <= n_rank;
        end
    end

    assign o_rank = r_rank;

endmodule

`default_nettype wire
